// ----- rtl/hafe_pkg.sv -----
// shared types, constants and header table for the annex b frame encapsulator
// no dependencies

package hafe_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int HDR_TABLE_LEN = 28;

  localparam logic [31:0] IDR_SLICE_HEADER = 32'h25b804ff;
  localparam logic [31:0] NONIDR_SLICE_HEADER = 32'h21e003ff;
  localparam logic [7:0] EPB_BYTE = 8'h03;

  localparam logic [5:0] IDR_HDR_LEN = 6'd32;
  localparam logic [5:0] NONIDR_HDR_LEN = 6'd8;
  // a non-idr header starts at the third start code of the table, the slice start code
  localparam logic [4:0] NONIDR_HDR_OFFSET = 5'd24;

  // one classified payload byte, handed from the front to the back
  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       idr;
    logic       last;
    logic       esc;
    logic [7:0] fnum;
  } cmd_t;

  // sps/pps block with its start codes, then the slice start code
  function automatic logic [7:0] hdr_table_byte(input logic [4:0] idx);
    logic [7:0] b;
    case (idx)
      5'd3:    b = 8'h01;
      5'd4:    b = 8'h67;
      5'd5:    b = 8'h64;
      5'd7:    b = 8'h20;
      5'd8:    b = 8'hac;
      5'd9:    b = 8'h2b;
      5'd10:   b = 8'h40;
      5'd11:   b = 8'h6c;
      5'd12:   b = 8'h1e;
      5'd13:   b = 8'hf3;
      5'd14:   b = 8'h68;
      5'd18:   b = 8'h01;
      5'd19:   b = 8'h68;
      5'd20:   b = 8'hee;
      5'd21:   b = 8'h06;
      5'd22:   b = 8'h0c;
      5'd23:   b = 8'he8;
      5'd27:   b = 8'h01;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ----- rtl/hafe_front.sv -----
// front end: accepts payload bytes, tracks zero run, payload index and frame number
// depends on hafe_pkg

module hafe_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic [7:0]        s_tdata,
  input  logic              s_tlast,
  input  logic [1:0]        s_tuser,
  input  logic              q_ready,
  output logic              push,
  output hafe_pkg::cmd_t    cmd
);

  logic [7:0] frame_number;
  logic [1:0] zero_run;
  logic [1:0] payload_index;
  logic [7:0] frame_number_next;
  logic [1:0] zero_run_next;
  logic [1:0] payload_index_next;

  logic       start;
  logic       idr;
  logic [1:0] zr0;
  logic [1:0] pi0;
  logic [1:0] zr_esc;
  logic       esc;

  assign start = s_tuser[0];
  assign idr   = s_tuser[1];
  assign push  = s_tvalid && q_ready;

  always_comb begin
    // header always ends in 0xff, so a new frame starts with no zeros behind it
    zr0 = start ? 2'd0 : zero_run;
    pi0 = start ? 2'd0 : payload_index;
    esc = (pi0 == 2'd2) && (s_tdata <= 8'd3) && (zr0 == 2'd2);
    zr_esc = esc ? 2'd0 : zr0;
    if (s_tdata == 8'd0) begin
      zero_run_next = (zr_esc == 2'd2) ? 2'd2 : zr_esc + 2'd1;
    end else begin
      zero_run_next = 2'd0;
    end
    payload_index_next = (pi0 == 2'd2) ? 2'd2 : pi0 + 2'd1;
    frame_number_next = (start && !idr) ? frame_number + 8'd1 : frame_number;

    cmd.data  = s_tdata;
    cmd.start = start;
    cmd.idr   = idr;
    cmd.last  = s_tlast;
    cmd.esc   = esc;
    cmd.fnum  = frame_number;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_number  <= 8'd0;
      zero_run      <= 2'd0;
      payload_index <= 2'd0;
    end else if (push) begin
      frame_number  <= frame_number_next;
      zero_run      <= zero_run_next;
      payload_index <= payload_index_next;
    end
  end

endmodule

// ----- rtl/hafe_queue.sv -----
// short command queue between front and back
// depends on hafe_pkg

module hafe_queue #(
  parameter int DEPTH = hafe_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  hafe_pkg::cmd_t    push_cmd,
  output logic              ready,
  input  logic              pop,
  output logic              head_valid,
  output hafe_pkg::cmd_t    head_cmd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  hafe_pkg::cmd_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign ready      = (count != CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ----- rtl/hafe_back.sv -----
// back end: walks header, escape and payload bytes of the head command into the output register
// depends on hafe_pkg

module hafe_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  hafe_pkg::cmd_t    head_cmd,
  output logic              pop,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata,
  output logic              m_tlast,
  output logic [0:0]        m_tuser
);

  logic [5:0]  pos;
  logic [5:0]  pos_next;
  logic        advance;
  logic [5:0]  hlen;
  logic [5:0]  last_pos;
  logic [4:0]  hp;
  logic [31:0] slice_hdr;
  logic [7:0]  hdr_byte;
  logic [7:0]  byte_next;
  logic        at_last;

  assign advance = head_valid && (!m_tvalid || m_tready);
  assign pop     = advance && at_last;

  always_comb begin
    if (head_cmd.start) begin
      hlen = head_cmd.idr ? hafe_pkg::IDR_HDR_LEN : hafe_pkg::NONIDR_HDR_LEN;
    end else begin
      hlen = 6'd0;
    end
    last_pos = hlen + {5'd0, head_cmd.esc};
    at_last  = (pos == last_pos);
    hp = pos[4:0] + (head_cmd.idr ? 5'd0 : hafe_pkg::NONIDR_HDR_OFFSET);

    if (head_cmd.idr) begin
      slice_hdr = hafe_pkg::IDR_SLICE_HEADER;
    end else begin
      slice_hdr = hafe_pkg::NONIDR_SLICE_HEADER | ({24'd0, head_cmd.fnum} << 13);
    end

    if (hp < 5'(hafe_pkg::HDR_TABLE_LEN)) begin
      hdr_byte = hafe_pkg::hdr_table_byte(hp);
    end else begin
      case (hp[1:0])
        2'd0:    hdr_byte = slice_hdr[31:24];
        2'd1:    hdr_byte = slice_hdr[23:16];
        2'd2:    hdr_byte = slice_hdr[15:8];
        default: hdr_byte = slice_hdr[7:0];
      endcase
    end

    if (pos < hlen) begin
      byte_next = hdr_byte;
    end else if (head_cmd.esc && (pos == hlen)) begin
      byte_next = hafe_pkg::EPB_BYTE;
    end else begin
      byte_next = head_cmd.data;
    end

    pos_next = at_last ? 6'd0 : pos + 6'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= 6'd0;
      m_tvalid <= 1'b0;
    end else begin
      if (advance) begin
        pos <= pos_next;
      end
      if (!m_tvalid || m_tready) begin
        m_tvalid <= head_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata    <= byte_next;
      m_tlast    <= at_last;
      m_tuser[0] <= at_last && head_cmd.last;
    end
  end

  // frame done only ever rides on the closing byte of a run
  a_done_on_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tlast)
    else $error("frame_done without last_of_run");

  // a command never runs past header, escape and data
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    pos <= hafe_pkg::IDR_HDR_LEN)
    else $error("byte position out of range");

  // position only moves while a command sits at the queue head
  a_pos_idle: assert property (@(posedge clk) disable iff (rst)
    !head_valid |-> pos == 6'd0)
    else $error("byte position set with empty queue");

endmodule

// ----- rtl/h264_annexb_frame_encapsulator_core.sv -----
// top level of the h.264 annex b frame encapsulator with emulation prevention
// depends on hafe_pkg, hafe_front, hafe_queue, hafe_back
//
// input stream: one raw slice payload byte per transfer on s_tdata, s_tlast marks
// the last byte of a frame, s_tuser carries frame_start and idr_frame. on a byte
// with frame_start the block emits, ahead of that byte, the sps/pps block (idr only),
// a start code and a 4-byte slice header; non-idr headers carry an 8-bit frame
// counter. payload bytes get an escape byte 0x03 inserted after two zero bytes when
// the byte is at most 3, never for the first two bytes of a frame.
// output stream: one byte per transfer, m_tlast on the final byte caused by an input
// byte, m_tuser[0] on the final byte of a frame.
// throughput: the output register moves one byte per cycle unless m_tready holds it;
// an input byte yields itself, plus an escape byte if needed, plus 8 (non-idr) or 32
// (idr) header bytes on a frame start; it passes the queue before the output register.
// the command queue lets input keep flowing while headers are sent or the receiver
// stalls; s_tready drops only once the queue is full.
// reset (rst, synchronous) clears the frame counter, escape tracking, queue and
// output valid.

module h264_annexb_frame_encapsulator_core #(
  parameter int QUEUE_DEPTH = hafe_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // payload_byte
  input  logic        s_tlast,   // end_of_frame
  input  logic [1:0]  s_tuser,   // [0] frame_start, [1] idr_frame
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // out_byte
  output logic        m_tlast,   // last_of_run
  output logic [0:0]  m_tuser    // [0] frame_done
);

  logic           push;
  logic           pop;
  logic           head_valid;
  hafe_pkg::cmd_t push_cmd;
  hafe_pkg::cmd_t head_cmd;

  hafe_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .q_ready  (s_tready),
    .push     (push),
    .cmd      (push_cmd)
  );

  hafe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .ready      (s_tready),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  hafe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .m_tuser    (m_tuser)
  );

endmodule

// ----- tb/testbench.sv -----
// self-checking testbench for h264_annexb_frame_encapsulator_core
// depends on hafe_pkg and the core; a byte-level predictor checks every output transfer

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 2000;
  localparam int TAIL_CYCLES = 40;
  // sps and pps units, each behind its own start code
  localparam logic [191:0] SPS_PPS =
    192'h00000001_6764_0020_ac2b_406c_1ef3_68_00000001_68ee_060c_e8;

  typedef struct packed {
    logic [7:0] payload;
    logic       sof;
    logic       eof;
    logic       idr;
    logic       wait_drain;   // hold the sender until the output has drained
  } payload_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
    logic       frame_done;
  } stream_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // payload_byte
  logic        s_tlast = 1'b0;    // end_of_frame
  logic [1:0]  s_tuser = 2'b00;   // [0] frame_start, [1] idr_frame
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;           // out_byte
  logic        m_tlast;           // last_of_run
  logic [0:0]  m_tuser;           // [0] frame_done

  payload_item_t pending[$];
  payload_item_t cur_item;
  stream_byte_t  expected_stream[$];

  // predictor state
  logic [7:0] frame_count = 8'd0;
  int         zero_count = 0;
  int         byte_index = 0;

  int  tx_gap = 0;
  int  rx_gap = 0;
  int  sent_count = 0;
  int  recv_count = 0;
  int  frames_seen = 0;
  int  idr_frames = 0;
  int  escapes_seen = 0;
  int  mismatch_count = 0;
  int  idle_cycles = 0;
  bit  timed_out = 1'b0;

  h264_annexb_frame_encapsulator_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int pick_gap(input bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_payload();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return 8'h00;
    if (r < 55) return 8'($urandom_range(1, 3));
    if (r < 60) return 8'h04;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void add_item(input logic [7:0] b, input bit sof, input bit eof,
                                   input bit idr);
    payload_item_t it;
    it.payload = b;
    it.sof = sof;
    it.eof = eof;
    it.idr = idr;
    it.wait_drain = 1'b0;
    pending.insert(pending.size(), it);
  endfunction

  function automatic void add_stream_byte(input logic [7:0] b);
    stream_byte_t e;
    e.data = b;
    e.run_end = 1'b0;
    e.frame_done = 1'b0;
    expected_stream.insert(expected_stream.size(), e);
    if (b == 8'h00) begin
      if (zero_count < 2) zero_count++;
    end else begin
      zero_count = 0;
    end
  endfunction

  // expected annex b bytes for one payload byte
  function automatic void encapsulate_byte(input payload_item_t it);
    logic [31:0]  hdr;
    stream_byte_t tail;
    if (it.sof) begin
      frames_seen++;
      if (it.idr) begin
        idr_frames++;
        for (int i = 0; i < 24; i++) add_stream_byte(SPS_PPS[191 - 8 * i -: 8]);
      end
      add_stream_byte(8'h00);
      add_stream_byte(8'h00);
      add_stream_byte(8'h00);
      add_stream_byte(8'h01);
      if (it.idr) begin
        hdr = hafe_pkg::IDR_SLICE_HEADER;
      end else begin
        hdr = hafe_pkg::NONIDR_SLICE_HEADER | ({24'd0, frame_count} << 13);
        frame_count = frame_count + 8'd1;
      end
      for (int i = 3; i >= 0; i--) add_stream_byte(hdr[8 * i +: 8]);
      byte_index = 0;
    end
    if (byte_index >= 2 && it.payload <= 8'h03 && zero_count >= 2) begin
      add_stream_byte(hafe_pkg::EPB_BYTE);
      escapes_seen++;
    end
    add_stream_byte(it.payload);
    if (byte_index < 2) byte_index++;
    tail = expected_stream.pop_back();
    tail.run_end = 1'b1;
    tail.frame_done = it.eof;
    expected_stream.insert(expected_stream.size(), tail);
  endfunction

  // sender
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        encapsulate_byte(cur_item);
        sent_count++;
      end
      if (!s_tvalid || s_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_tvalid <= 1'b0;
        end else if (pending.size() > 0 &&
                     !(pending[0].wait_drain && expected_stream.size() != 0)) begin
          cur_item = pending.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= cur_item.payload;
          s_tlast <= cur_item.eof;
          s_tuser <= {cur_item.idr, cur_item.sof};
          tx_gap = pick_gap(((sent_count / 64) % 3) == 2);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    stream_byte_t exp_byte;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        recv_count++;
        if (expected_stream.size() == 0) begin
          $error("unexpected output transfer: out_byte %h", m_tdata);
          mismatch_count++;
        end else begin
          exp_byte = expected_stream.pop_front();
          if (m_tdata !== exp_byte.data) begin
            $error("out_byte: expected %h, got %h", exp_byte.data, m_tdata);
            mismatch_count++;
          end
          if (m_tlast !== exp_byte.run_end) begin
            $error("last_of_run: expected %b, got %b", exp_byte.run_end, m_tlast);
            mismatch_count++;
          end
          if (m_tuser[0] !== exp_byte.frame_done) begin
            $error("frame_done: expected %b, got %b", exp_byte.frame_done, m_tuser[0]);
            mismatch_count++;
          end
        end
      end
      if (rx_gap > 0) begin
        rx_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (((recv_count / 300) % 3) != 1 && $urandom_range(0, 3) == 0)
          rx_gap = pick_gap(1'b0);
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) timed_out = 1'b1;
    end
  end

  initial begin
    int r;
    int len;
    bit idr;
    payload_item_t tmp;

    // bytes ahead of any frame, idr flag set off frame start
    add_item(8'h00, 0, 0, 1);
    add_item(8'h00, 0, 0, 0);
    add_item(8'h02, 0, 0, 0);
    // idr frame with zero runs around the escape threshold
    add_item(8'h00, 1, 0, 1);
    add_item(8'h00, 0, 0, 0);
    add_item(8'h00, 0, 0, 1);
    add_item(8'h03, 0, 0, 0);
    add_item(8'h00, 0, 0, 0);
    add_item(8'h00, 0, 0, 0);
    add_item(8'h04, 0, 0, 0);
    add_item(8'h00, 0, 0, 0);
    add_item(8'h00, 0, 0, 0);
    add_item(8'h01, 0, 0, 0);
    add_item(8'hff, 0, 1, 0);
    // one-byte frame
    add_item(8'h7f, 1, 1, 0);
    // frame abandoned by an early start
    add_item(8'h00, 1, 0, 0);
    add_item(8'h00, 0, 0, 0);
    add_item(8'h80, 0, 0, 0);
    add_item(8'h00, 1, 0, 0);
    add_item(8'h00, 0, 0, 0);
    add_item(8'h00, 0, 0, 0);
    add_item(8'h03, 0, 1, 0);
    // continuation bytes after a frame end
    add_item(8'h00, 0, 0, 1);
    add_item(8'h00, 0, 0, 0);
    add_item(8'h00, 0, 0, 0);

    while (pending.size() < 345) begin
      r = $urandom_range(0, 99);
      if (r < 70) len = $urandom_range(1, 4);
      else if (r < 95) len = $urandom_range(5, 16);
      else len = $urandom_range(17, 40);
      r = $urandom_range(0, 99);
      if (r < 85) begin
        idr = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < len; i++)
          add_item(pick_payload(), i == 0, i == len - 1, i == 0 ? idr : 1'($urandom));
      end else if (r < 93) begin
        // no end mark, the next start abandons it
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++)
          add_item(pick_payload(), i == 0, 1'b0, 1'($urandom));
      end else begin
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++)
          add_item(pick_payload(), 1'b0, 1'($urandom), 1'($urandom));
      end
    end

    tmp = pending[25];
    tmp.wait_drain = 1'b1;
    pending[25] = tmp;
    tmp = pending[200];
    tmp.wait_drain = 1'b1;
    pending[200] = tmp;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    while (!timed_out &&
           !(pending.size() == 0 && !s_tvalid && expected_stream.size() == 0))
      @(negedge clk);
    if (!timed_out) repeat (TAIL_CYCLES) @(negedge clk);

    if (timed_out) begin
      $display("testbench NOT OK");
    end else begin
      $display("sent %0d payload bytes in %0d frames (%0d idr), checked %0d output bytes",
               sent_count, frames_seen, idr_frames, recv_count);
      $display("%0d escape bytes predicted, %0d mismatches", escapes_seen, mismatch_count);
      if (mismatch_count == 0 && expected_stream.size() == 0)
        $display("testbench OK");
      else
        $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
